FILE: sv/sstod_pkg.sv
// types and constants shared by the serial-set time-of-day clock
// no dependencies; compiled first
package sstod_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [6:0] field_t;

	// command codes of an input transaction
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// characters
	localparam byte_t CHAR_NEWLINE = 8'h0A;
	localparam byte_t CHAR_COLON   = 8'h3A;
	localparam byte_t CHAR_ZERO    = 8'h30;
	localparam byte_t CHAR_NINE    = 8'h39;

	// only the first bytes of a line take part in matching
	localparam int KEEP_BYTES = 12;
	localparam int RESET_LEN  = 12;
	localparam int TIME_LEN   = 8;
	localparam int COLON_POS0 = 2;
	localparam int COLON_POS1 = 5;

	localparam byte_t RESET_WORD [KEEP_BYTES] = '{
		8'h52, 8'h45, 8'h53, 8'h45, 8'h54, 8'h5F,
		8'h53, 8'h59, 8'h53, 8'h54, 8'h45, 8'h4D
	};

	// time limits
	localparam field_t SEC_WRAP  = 7'd60;
	localparam field_t MIN_WRAP  = 7'd60;
	localparam field_t HOUR_WRAP = 7'd24;
	localparam field_t FIELD_MAX = 7'd100;

	typedef struct packed {
		logic   command;
		byte_t  rx_byte;
	} item_t;

	typedef struct packed {
		field_t hours;
		field_t minutes;
		field_t seconds;
	} result_t;

	// action decoded from a completed line
	typedef struct packed {
		logic   clear;
		logic   load;
		field_t hours;
		field_t minutes;
		field_t seconds;
	} line_cmd_t;

endpackage

FILE: sv/sstod_stream_if.sv
// valid/ready channel carrying one payload per transaction
// payload type given by the instantiating side; no package dependency
interface sstod_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/sstod_line.sv
// line collector and decoder: gathers bytes, decodes the line on newline
// depends on sstod_pkg
module sstod_line #(
	parameter int LINE_CAPACITY = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_en,
	input  sstod_pkg::byte_t  rx_byte,
	output sstod_pkg::line_cmd_t line_cmd
);
	import sstod_pkg::*;

	localparam int STORE_DEPTH = LINE_CAPACITY - 1;
	localparam int LEN_W       = $clog2(LINE_CAPACITY);

	logic [LEN_W-1:0] len_q;
	byte_t            line_q [KEEP_BYTES];
	logic             is_newline;
	logic             store_en;
	logic             reset_match;
	logic             time_match;

	assign is_newline = (rx_byte == CHAR_NEWLINE);
	assign store_en   = byte_en && !is_newline && (len_q < LEN_W'(STORE_DEPTH));

	// line length, emptied on newline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (byte_en && is_newline) begin
			len_q <= '0;
		end else if (store_en) begin
			len_q <= len_q + 1'b1;
		end
	end

	// kept bytes; later bytes only count toward the length
	always_ff @(posedge clk) begin
		for (int i = 0; i < KEEP_BYTES; i++) begin
			if (store_en && len_q == LEN_W'(i)) begin
				line_q[i] <= rx_byte;
			end
		end
	end

	function automatic logic is_digit(input byte_t c);
		return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

	function automatic field_t two_digits(input byte_t hi, input byte_t lo);
		logic [3:0] t;
		logic [3:0] u;
		t = 4'(hi - CHAR_ZERO);
		u = 4'(lo - CHAR_ZERO);
		return {t, 3'b000} + {2'b00, t, 1'b0} + {3'b000, u};
	endfunction

	// match the two known line forms
	always_comb begin
		reset_match = (len_q == LEN_W'(RESET_LEN));
		for (int i = 0; i < KEEP_BYTES; i++) begin
			if (line_q[i] != RESET_WORD[i]) begin
				reset_match = 1'b0;
			end
		end
		time_match = (len_q == LEN_W'(TIME_LEN))
			&& line_q[COLON_POS0] == CHAR_COLON && line_q[COLON_POS1] == CHAR_COLON
			&& is_digit(line_q[0]) && is_digit(line_q[1])
			&& is_digit(line_q[3]) && is_digit(line_q[4])
			&& is_digit(line_q[6]) && is_digit(line_q[7]);
	end

	assign line_cmd.clear   = byte_en && is_newline && reset_match;
	assign line_cmd.load    = byte_en && is_newline && !reset_match && time_match;
	assign line_cmd.hours   = two_digits(line_q[0], line_q[1]);
	assign line_cmd.minutes = two_digits(line_q[3], line_q[4]);
	assign line_cmd.seconds = two_digits(line_q[6], line_q[7]);

endmodule

FILE: sv/sstod_time.sv
// time counters with fresh mark: load, clear and one-second advance
// depends on sstod_pkg
module sstod_time (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tick,
	input  sstod_pkg::line_cmd_t line_cmd,
	output sstod_pkg::result_t   now
);
	import sstod_pkg::*;

	field_t hours_q;
	field_t minutes_q;
	field_t seconds_q;
	logic   fresh_q;
	field_t sec_inc;
	field_t min_inc;
	field_t hour_inc;
	field_t sec_nxt;
	field_t min_nxt;
	field_t hour_nxt;
	logic   min_carry;
	logic   hour_carry;

	// advance by one second, each wrap test applied on its own
	always_comb begin
		sec_inc   = seconds_q + 7'd1;
		min_carry = (sec_inc == SEC_WRAP);
		sec_nxt   = (min_carry || sec_inc >= FIELD_MAX) ? '0 : sec_inc;

		min_inc    = minutes_q + {6'd0, min_carry};
		hour_carry = (min_inc == MIN_WRAP);
		min_nxt    = (hour_carry || min_inc >= FIELD_MAX) ? '0 : min_inc;

		hour_inc = hours_q + {6'd0, hour_carry};
		hour_nxt = (hour_inc == HOUR_WRAP || hour_inc >= FIELD_MAX) ? '0 : hour_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hours_q   <= '0;
			minutes_q <= '0;
			seconds_q <= '0;
			fresh_q   <= 1'b0;
		end else if (line_cmd.clear) begin
			hours_q   <= '0;
			minutes_q <= '0;
			seconds_q <= '0;
			fresh_q   <= 1'b0;
		end else if (line_cmd.load) begin
			hours_q   <= line_cmd.hours;
			minutes_q <= line_cmd.minutes;
			seconds_q <= line_cmd.seconds;
			fresh_q   <= 1'b1;
		end else if (tick) begin
			if (fresh_q) begin
				fresh_q <= 1'b0;
			end else begin
				hours_q   <= hour_nxt;
				minutes_q <= min_nxt;
				seconds_q <= sec_nxt;
			end
		end
	end

	assign now.hours   = hours_q;
	assign now.minutes = minutes_q;
	assign now.seconds = seconds_q;

endmodule

FILE: sv/serial_set_time_of_day_clock.sv
// time-of-day clock set over a serial byte stream and advanced by ticks
// item channel: command 0 carries a received byte in rx_byte, command 1 is a
// one-second tick. result channel: one transaction per tick with the hours,
// minutes and seconds held before that tick acts.
// a byte produces no result; a newline acts on the gathered line: a line
// holding the clear word clears the time, a line DD:DD:DD loads it and marks
// it fresh. a tick after a load only clears the fresh mark, otherwise it
// advances time.
// the result of a tick is registered and valid the cycle after the tick is taken.
// throughput: one item per cycle, held by the single result register; an
// item is taken while that register is empty or being drained.
// when the receiver stalls with a result waiting, ready drops and no item is
// taken until the result is accepted.
// reset clears the time, fresh mark, line length and result valid.
// depends on sstod_pkg, sstod_stream_if, sstod_line, sstod_time
module serial_set_time_of_day_clock #(
	parameter int LINE_CAPACITY = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	sstod_stream_if.sink   item,
	sstod_stream_if.source result
);
	import sstod_pkg::*;

	logic      item_fire;
	logic      tick_fire;
	logic      byte_fire;
	logic      res_valid_q;
	result_t   res_q;
	result_t   now;
	line_cmd_t line_cmd;

	// accept while the result register is free or draining
	assign item.ready = !res_valid_q || result.ready;
	assign item_fire  = item.valid && item.ready;
	assign tick_fire  = item_fire && (item.payload.command == CMD_TICK);
	assign byte_fire  = item_fire && (item.payload.command == CMD_BYTE);

	sstod_line #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_en (byte_fire),
		.rx_byte (item.payload.rx_byte),
		.line_cmd(line_cmd)
	);

	sstod_time u_time (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick_fire),
		.line_cmd(line_cmd),
		.now     (now)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (tick_fire) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_fire) begin
			res_q <= now;
		end
	end

	assign result.valid   = res_valid_q;
	assign result.payload = res_q;

endmodule
